FILE: rtl/cac_pkg.sv
// Countdown alarm controller: shared types, constants and the alarm note pattern.
// No dependencies; used by the interfaces, cac_step and the top level.
package cac_pkg;

    localparam int unsigned PATTERN_STEPS = 15;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 10;

    localparam logic [7:0] NOTE_SILENT = 8'h01;
    localparam logic [7:0] NOTE_HIGH   = 8'h24;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_BUTTON = 2'd1,
        OP_WHEEL  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTDOWN_PERIOD = 3'd0,
        REG_TICKS_PER_MINUTE = 3'd1,
        REG_STEP_PERIOD      = 3'd2,
        REG_MELODY_PLAYS     = 3'd3,
        REG_CLICK_TONE       = 3'd4,
        REG_CLICK_LENGTH     = 3'd5,
        REG_LOCKOUT_TICKS    = 3'd6,
        REG_SCAN_PERIOD      = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] countdown_period;
        logic [9:0] ticks_per_minute;
        logic [9:0] step_period;
        logic [7:0] melody_plays;
        logic [7:0] click_tone;
        logic [7:0] click_length;
        logic [3:0] lockout_ticks;
        logic [3:0] scan_period;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        countdown_period: 8'd247,
        ticks_per_minute: 10'd960,
        step_period:      10'd500,
        melody_plays:     8'd150,
        click_tone:       8'h50,
        click_length:     8'hEE,
        lockout_ticks:    4'd2,
        scan_period:      4'd5
    };

    typedef struct packed {
        logic disp;
        logic count;
        logic play;
        logic beep;
    } t_flags;

    typedef struct packed {
        logic [7:0] minutes;
        logic [9:0] prescale;
        logic [7:0] countdown_timer;
        logic [9:0] step_timer;
        logic [3:0] pattern_index;
        logic [7:0] plays_left;
        logic [7:0] note;
        t_flags     flags;
        logic       toggle;
        logic [3:0] scan_timer;
        logic [7:0] click_timer;
        logic [3:0] lock_button;
        logic [3:0] lock_wheel;
    } t_state;

    localparam t_state STATE_RESET = '{
        minutes:         8'd0,
        prescale:        CFG_RESET.ticks_per_minute,
        countdown_timer: 8'd0,
        step_timer:      10'd0,
        pattern_index:   4'd0,
        plays_left:      CFG_RESET.melody_plays,
        note:            8'd0,
        flags:           '0,
        toggle:          1'b0,
        scan_timer:      4'd0,
        click_timer:     8'd0,
        lock_button:     4'd0,
        lock_wheel:      4'd0
    };

    typedef struct packed {
        logic [7:0] minutes_left;
        logic       display_enabled;
        logic       digit_select;
        logic [3:0] digit_value;
        logic       tone_on;
        logic [7:0] tone_period;
        logic       alarm_playing;
    } t_result;

    // Alarm pattern: two short high notes, rest silent
    function automatic logic [7:0] pattern_note(input logic [3:0] idx);
        return (idx == 4'd0 || idx == 4'd2) ? NOTE_HIGH : NOTE_SILENT;
    endfunction

endpackage

FILE: rtl/cac_if.sv
// Countdown alarm controller: request, result and configuration channels.
// Depends on cac_pkg.
interface cac_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       button_level;
    logic       wheel_a;
    logic       wheel_b;
    modport source (output valid, op, button_level, wheel_a, wheel_b, input ready);
    modport sink   (input valid, op, button_level, wheel_a, wheel_b, output ready);
endinterface

interface cac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] minutes_left;
    logic       display_enabled;
    logic       digit_select;
    logic [3:0] digit_value;
    logic       tone_on;
    logic [7:0] tone_period;
    logic       alarm_playing;
    modport source (output valid, minutes_left, display_enabled, digit_select, digit_value,
                    tone_on, tone_period, alarm_playing, input ready);
    modport sink   (input valid, minutes_left, display_enabled, digit_select, digit_value,
                    tone_on, tone_period, alarm_playing, output ready);
endinterface

interface cac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cac_pkg::CFG_IDX_W-1:0]  index;
    logic [cac_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/cac_step.sv
// Countdown alarm controller: next-state and result logic for one request.
// Purely combinational; depends on cac_pkg.
module cac_step (
    input  cac_pkg::t_state  i_state,
    input  cac_pkg::t_cfg    i_cfg,
    input  logic [1:0]       i_op,
    input  logic             i_button_level,
    input  logic             i_wheel_a,
    input  logic             i_wheel_b,
    output cac_pkg::t_state  o_state,
    output cac_pkg::t_result o_result
);

    function automatic logic [7:0] f_max1_8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic [9:0] f_max1_10(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    function automatic logic [3:0] f_max1_4(input logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

    function automatic cac_pkg::t_state f_start_display(cac_pkg::t_state s,
                                                        cac_pkg::t_cfg c);
        cac_pkg::t_state r;
        r = s;
        if (!r.flags.disp) begin
            r.flags.disp = 1'b1;
            r.toggle     = ~r.toggle;
            r.scan_timer = f_max1_4(c.scan_period);
        end
        return r;
    endfunction

    function automatic cac_pkg::t_state f_alarm_step(cac_pkg::t_state s, cac_pkg::t_cfg c);
        cac_pkg::t_state r;
        logic [4:0]      nidx;
        r    = s;
        nidx = {1'b0, s.pattern_index} + 5'd1;
        if (r.flags.play) begin
            r.plays_left = r.plays_left - 8'd1;
            if (r.plays_left == 8'd0) begin
                r.flags = '0;
            end else begin
                r.note = cac_pkg::pattern_note(r.pattern_index);
                if (r.note == cac_pkg::NOTE_SILENT) begin
                    r.flags.beep = 1'b0;
                    r            = f_start_display(r, c);
                end else begin
                    r.flags.beep = 1'b1;
                    r.flags.disp = 1'b0;
                end
                r.pattern_index = (nidx >= 5'(cac_pkg::PATTERN_STEPS)) ? 4'd0 : nidx[3:0];
                r.step_timer    = f_max1_10(c.step_period);
            end
        end
        return r;
    endfunction

    // Prescaler step; a minutes decrement landing on zero starts the alarm
    function automatic cac_pkg::t_state f_countdown_run(cac_pkg::t_state s,
                                                        cac_pkg::t_cfg c);
        cac_pkg::t_state r;
        r = s;
        r.countdown_timer = f_max1_8(c.countdown_period);
        if (!r.flags.play) begin
            if (r.prescale <= 10'd1) begin
                r.prescale = f_max1_10(c.ticks_per_minute);
                r.minutes  = r.minutes - 8'd1;
                if (r.minutes == 8'd0) begin
                    r.flags.play    = 1'b1;
                    r.plays_left    = c.melody_plays;
                    r.pattern_index = 4'd0;
                    r               = f_alarm_step(r, c);
                end
            end else begin
                r.prescale = r.prescale - 10'd1;
            end
        end
        return r;
    endfunction

    cac_pkg::t_state s;

    always_comb begin
        s = i_state;
        unique case (cac_pkg::t_op'(i_op))
            cac_pkg::OP_TICK: begin
                if (s.lock_button != 4'd0) s.lock_button = s.lock_button - 4'd1;
                if (s.lock_wheel != 4'd0)  s.lock_wheel  = s.lock_wheel - 4'd1;
                if (s.click_timer != 8'd0) begin
                    s.click_timer = s.click_timer - 8'd1;
                    if (s.click_timer == 8'd0) s.flags.beep = 1'b0;
                end
                if (s.flags.disp) begin
                    if (s.scan_timer <= 4'd1) begin
                        s.toggle     = ~s.toggle;
                        s.scan_timer = f_max1_4(i_cfg.scan_period);
                    end else begin
                        s.scan_timer = s.scan_timer - 4'd1;
                    end
                end
                if (s.flags.count) begin
                    if (s.countdown_timer <= 8'd1) s = f_countdown_run(s, i_cfg);
                    else s.countdown_timer = s.countdown_timer - 8'd1;
                end
                // may run a second pattern step when the alarm just started
                if (s.flags.play) begin
                    if (s.step_timer <= 10'd1) s = f_alarm_step(s, i_cfg);
                    else s.step_timer = s.step_timer - 10'd1;
                end
            end
            cac_pkg::OP_BUTTON: begin
                if (s.lock_button == 4'd0) begin
                    s.lock_button = i_cfg.lockout_ticks;
                    if (i_button_level) begin
                        s.minutes     = 8'd0;
                        s.flags       = '0;
                        s.flags.beep  = 1'b1;
                        s.note        = i_cfg.click_tone;
                        s.click_timer = f_max1_8(i_cfg.click_length);
                    end
                end
            end
            cac_pkg::OP_WHEEL: begin
                if (s.lock_wheel == 4'd0) begin
                    s.lock_wheel = i_cfg.lockout_ticks;
                    if (!i_wheel_a) begin
                        s.minutes    = i_wheel_b ? s.minutes + 8'd1 : s.minutes - 8'd1;
                        s.prescale   = f_max1_10(i_cfg.ticks_per_minute);
                        s.flags.play = 1'b0;
                        s.flags.beep = 1'b0;
                        s            = f_start_display(s, i_cfg);
                        if (!s.flags.count) begin
                            s.flags.count = 1'b1;
                            s             = f_countdown_run(s, i_cfg);
                        end
                    end
                end
            end
            cac_pkg::OP_NONE: ;
        endcase
    end

    assign o_state = s;

    always_comb begin
        o_result.minutes_left    = s.minutes;
        o_result.display_enabled = s.flags.disp;
        o_result.digit_select    = s.toggle;
        o_result.digit_value     = !s.flags.disp ? 4'd0
                                 : (s.toggle ? s.minutes[7:4] : s.minutes[3:0]);
        o_result.tone_on         = s.flags.beep;
        o_result.tone_period     = s.note;
        o_result.alarm_playing   = s.flags.play;
    end

endmodule

FILE: rtl/countdown_alarm_controller_top.sv
// Countdown alarm controller, top level.
// The result is registered: it is presented in the cycle after its request is accepted.
// One request per cycle while o_res.ready holds; the result register alone sets the stall.
// Reset (i_rst_n low, synchronous): configuration back to defaults, all timers,
// flags and lockouts cleared, prescaler and play budget loaded, result dropped.
// Depends on cac_pkg, cac_if and cac_step.
module countdown_alarm_controller_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cac_in_if.sink    i_in,
    cac_cfg_if.sink   i_cfg,
    cac_out_if.source o_res
);

    // Configuration registers, always writable; the user is to touch them only while idle (not enforced here)
    cac_pkg::t_cfg    r_cfg;

    // Architectural state, updated on every accepted request
    cac_pkg::t_state  r_state;
    cac_pkg::t_state  n_state;

    // Result register: parts request and result sides
    cac_pkg::t_result r_result;
    cac_pkg::t_result n_result;
    logic             r_out_valid;

    logic             in_accept;

    assign i_cfg.ready = 1'b1;

    // Take a new request whenever the result slot is free or drains this cycle
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    cac_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_op           (i_in.op),
        .i_button_level (i_in.button_level),
        .i_wheel_a      (i_in.wheel_a),
        .i_wheel_b      (i_in.wheel_b),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cac_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (cac_pkg::t_cfg_reg'(i_cfg.index))
                cac_pkg::REG_COUNTDOWN_PERIOD: r_cfg.countdown_period <= i_cfg.data[7:0];
                cac_pkg::REG_TICKS_PER_MINUTE: r_cfg.ticks_per_minute <= i_cfg.data[9:0];
                cac_pkg::REG_STEP_PERIOD:      r_cfg.step_period      <= i_cfg.data[9:0];
                cac_pkg::REG_MELODY_PLAYS:     r_cfg.melody_plays     <= i_cfg.data[7:0];
                cac_pkg::REG_CLICK_TONE:       r_cfg.click_tone       <= i_cfg.data[7:0];
                cac_pkg::REG_CLICK_LENGTH:     r_cfg.click_length     <= i_cfg.data[7:0];
                cac_pkg::REG_LOCKOUT_TICKS:    r_cfg.lockout_ticks    <= i_cfg.data[3:0];
                cac_pkg::REG_SCAN_PERIOD:      r_cfg.scan_period      <= i_cfg.data[3:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cac_pkg::STATE_RESET;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.minutes_left    = r_result.minutes_left;
    assign o_res.display_enabled = r_result.display_enabled;
    assign o_res.digit_select    = r_result.digit_select;
    assign o_res.digit_value     = r_result.digit_value;
    assign o_res.tone_on         = r_result.tone_on;
    assign o_res.tone_period     = r_result.tone_period;
    assign o_res.alarm_playing   = r_result.alarm_playing;

endmodule
